// ----- src/fcd_pkg.sv -----
// Shared constants, codes and types for the frame catch and decode block.
`default_nettype none
package fcd_pkg;

    localparam int BUF_DEPTH_DEF = 64;

    localparam int STATUS_W = 4;
    localparam int PLEN_W   = 6;
    localparam int LEN_W    = 16;

    // command codes
    localparam logic CMD_RX   = 1'b0;
    localparam logic CMD_TAKE = 1'b1;

    // framing bytes
    localparam logic [7:0] START_BYTE = 8'hFA;
    localparam logic [7:0] END_BYTE   = 8'hFB;
    localparam logic [7:0] ESC_BYTE   = 8'h2F;
    localparam logic [7:0] FLIP_MASK  = 8'h80;

    // frame layout: STX, four length bytes, data, checksum pair, ETX
    localparam int HDR_FIRST  = 1;
    localparam int HDR_LAST   = 4;
    localparam int DATA_FIRST = 5;
    localparam int LEN_MARGIN = 8;

    // capture state codes
    localparam logic [1:0] CS_IDLE     = 2'd0;
    localparam logic [1:0] CS_CATCHING = 2'd1;
    localparam logic [1:0] CS_COMPLETE = 2'd2;
    localparam logic [1:0] CS_LOCKED   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_BYTE    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_OK      = 4'd5;
    localparam logic [STATUS_W-1:0] ST_NONE    = 4'd6;
    localparam logic [STATUS_W-1:0] ST_CRC_ERR = 4'd7;
    localparam logic [STATUS_W-1:0] ST_LEN_ERR = 4'd8;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          data_byte;
        logic [PLEN_W-1:0]   payload_length;
        logic                package_waiting;
        logic                last;
    } t_res;

    typedef struct packed {
        logic [1:0] state;
        logic       ready;
    } t_catch;

endpackage
`default_nettype wire

// ----- src/fcd_if.sv -----
// Valid/ready channel interfaces for the input commands and the results.
`default_nettype none
interface fcd_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface fcd_out_if;
    logic                          valid;
    logic                          ready;
    logic [fcd_pkg::STATUS_W-1:0]  status;
    logic [7:0]                    data_byte;
    logic [fcd_pkg::PLEN_W-1:0]    payload_length;
    logic                          package_waiting;
    logic                          last;

    modport source (output valid, output status, output data_byte, output payload_length,
                    output package_waiting, output last, input ready);
    modport sink   (input valid, input status, input data_byte, input payload_length,
                    input package_waiting, input last, output ready);
endinterface
`default_nettype wire

// ----- src/frame_catch_and_decode_top.sv -----
// Top level: input handshake, capture control, frame store, take sequencer, result register.
// Receive bytes stream one per cycle while the sink keeps up and no take runs; each
// result sits in the result register next cycle. A take walks the store in read/use
// steps (header, data, checksum pair, then data again to unescape); a length error stops
// after the header, a checksum error after the pair; input is held to the end of the take.
// Reset (synchronous, active low) clears capture state, count, lock flag and sequencer;
// the frame store is not cleared.
`default_nettype none
module frame_catch_and_decode_top #(
    parameter int BUF_DEPTH = fcd_pkg::BUF_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fcd_in_if.sink            i_in,
    fcd_out_if.source         o_out
);
    import fcd_pkg::*;

    localparam int IDX_W = $clog2(BUF_DEPTH);
    localparam int CNT_W = $clog2(BUF_DEPTH + 1);

    // store ports
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;

    // capture side
    logic [CNT_W-1:0] cat_count;
    logic             cat_ready;
    t_catch           cat_next;

    // decode side
    logic             dec_valid;
    t_res             dec_res;
    logic             dec_busy;

    // handshake
    logic slot_free;
    logic in_ready;
    logic in_xfer;
    logic rx_en;
    logic take;
    logic start;
    logic none;

    // result register
    logic r_out_valid;
    t_res r_out;
    t_res n_out;
    logic load;

    // The result register frees up in the same cycle it is drained, so receive
    // transfers flow one per cycle as long as the sink keeps up.
    assign slot_free = !r_out_valid || o_out.ready;
    // While a take is being walked nothing else is accepted.
    assign in_ready  = !dec_busy && slot_free;
    assign i_in.ready = in_ready;

    assign in_xfer = i_in.valid && in_ready;
    assign rx_en   = in_xfer && (i_in.cmd == CMD_RX);
    assign take    = in_xfer && (i_in.cmd == CMD_TAKE);
    assign start   = take && cat_ready;
    assign none    = take && !cat_ready;

    fcd_catch #(
        .BUF_DEPTH (BUF_DEPTH),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_catch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx_en   (rx_en),
        .i_rx_byte (i_in.rx_byte),
        .i_clear   (start),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_count   (cat_count),
        .o_ready   (cat_ready),
        .o_next    (cat_next)
    );

    // Writes only happen on receive transfers and reads only during a take,
    // so the ports never touch the same entry in the same cycle.
    fcd_store #(
        .DEPTH (BUF_DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Sequencer gets the fill count as it stood at the take transfer.
    fcd_decode #(
        .BUF_DEPTH (BUF_DEPTH),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_count     (cat_count),
        .i_rd_data   (rd_data),
        .i_slot_free (slot_free),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_res_valid (dec_valid),
        .o_res       (dec_res),
        .o_busy      (dec_busy)
    );

    // Result select: receive status, empty take, or sequencer output.
    always_comb begin
        n_out                 = '0;
        n_out.last            = 1'b1;
        load                  = 1'b0;
        if (rx_en) begin
            load                  = 1'b1;
            n_out.status          = STATUS_W'(cat_next.state);
            n_out.package_waiting = cat_next.ready;
        end else if (none) begin
            load         = 1'b1;
            n_out.status = ST_NONE;
        end else if (dec_valid && slot_free) begin
            load  = 1'b1;
            n_out = dec_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out.status;
    assign o_out.data_byte       = r_out.data_byte;
    assign o_out.payload_length  = r_out.payload_length;
    assign o_out.package_waiting = r_out.package_waiting;
    assign o_out.last            = r_out.last;
endmodule
`default_nettype wire

// ----- src/fcd_store.sv -----
// Frame store: single write port, single registered read port.
`default_nettype none
module fcd_store #(
    parameter int DEPTH = fcd_pkg::BUF_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [7:0]       i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [7:0]       o_rd_data
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

// ----- src/fcd_catch.sv -----
// Capture control: start/end byte tracking, fill count and lock flag.
`default_nettype none
module fcd_catch #(
    parameter int BUF_DEPTH = fcd_pkg::BUF_DEPTH_DEF,
    parameter int IDX_W     = $clog2(BUF_DEPTH),
    parameter int CNT_W     = $clog2(BUF_DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rx_en,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_clear,
    output logic                o_wr_en,
    output logic [IDX_W-1:0]    o_wr_addr,
    output logic [7:0]          o_wr_data,
    output logic [CNT_W-1:0]    o_count,
    output logic                o_ready,
    output fcd_pkg::t_catch     o_next
);
    import fcd_pkg::*;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ready;
    logic             n_ready;
    logic             full;

    assign full = (r_count >= CNT_W'(BUF_DEPTH));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ready   = r_ready;
        o_wr_en   = 1'b0;
        o_wr_addr = r_count[IDX_W-1:0];
        o_wr_data = i_rx_byte;
        if (i_clear) begin
            n_state = CS_IDLE;
            n_count = '0;
            n_ready = 1'b0;
        end else if (i_rx_en) begin
            if (r_ready) begin
                n_state = CS_LOCKED;
            end else if (i_rx_byte == START_BYTE) begin
                o_wr_en   = 1'b1;
                o_wr_addr = '0;
                n_count   = CNT_W'(1);
                n_state   = CS_CATCHING;
            end else if (i_rx_byte == END_BYTE) begin
                if (r_state != CS_CATCHING || full) begin
                    n_state = CS_IDLE;
                    n_count = '0;
                end else begin
                    o_wr_en = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_state = CS_COMPLETE;
                    n_ready = 1'b1;
                end
            end else if (r_state == CS_CATCHING) begin
                if (full) begin
                    n_state = CS_IDLE;
                    n_count = '0;
                end else begin
                    o_wr_en = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_count <= '0;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ready <= n_ready;
        end
    end

    assign o_count      = r_count;
    assign o_ready      = r_ready;
    assign o_next.state = n_state;
    assign o_next.ready = n_ready;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(BUF_DEPTH))
        else $error("fill count beyond store depth");

    a_ready_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_state == CS_COMPLETE || r_state == CS_LOCKED))
        else $error("package waiting while not complete or locked");

    a_catch_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CS_CATCHING) |-> (r_count != '0))
        else $error("catching with empty store");
endmodule
`default_nettype wire

// ----- src/fcd_decode.sv -----
// Take sequencer: header, length check, checksum pass, unescaping pass.
`default_nettype none
module fcd_decode #(
    parameter int BUF_DEPTH = fcd_pkg::BUF_DEPTH_DEF,
    parameter int IDX_W     = $clog2(BUF_DEPTH),
    parameter int CNT_W     = $clog2(BUF_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CNT_W-1:0] i_count,
    input  logic [7:0]       i_rd_data,
    input  logic             i_slot_free,
    output logic             o_rd_en,
    output logic [IDX_W-1:0] o_rd_addr,
    output logic             o_res_valid,
    output fcd_pkg::t_res    o_res,
    output logic             o_busy
);
    import fcd_pkg::*;

    localparam logic [2:0] SQ_IDLE = 3'd0;
    localparam logic [2:0] SQ_RD   = 3'd1;
    localparam logic [2:0] SQ_USE  = 3'd2;
    localparam logic [2:0] SQ_LCK  = 3'd3;
    localparam logic [2:0] SQ_FIN  = 3'd4;

    localparam logic [1:0] PH_HDR = 2'd0;
    localparam logic [1:0] PH_CHK = 2'd1;
    localparam logic [1:0] PH_DEC = 2'd2;

    logic [2:0]          r_state;
    logic [1:0]          r_phase;
    logic [CNT_W-1:0]    r_pos;
    logic [CNT_W-1:0]    r_cur;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_end;
    logic [LEN_W-1:0]    r_len;
    logic [7:0]          r_crc;
    logic [7:0]          r_c0;
    logic                r_esc;
    logic [PLEN_W-1:0]   r_oi;
    logic [STATUS_W-1:0] r_fin;

    logic       emit;
    logic [7:0] dec_val;
    logic [7:0] rx_sum;
    logic       len_bad;
    logic       dec_done;

    assign emit     = (r_state == SQ_USE) && (r_phase == PH_DEC)
                    && (r_esc || (i_rd_data != ESC_BYTE));
    assign dec_val  = !r_esc ? i_rd_data
                    : ((i_rd_data == ESC_BYTE) ? ESC_BYTE : (i_rd_data ^ FLIP_MASK));
    assign rx_sum   = i_rd_data | {4'h0, r_c0[7:4]} | {i_rd_data[3:0], 4'h0};
    assign len_bad  = ({1'b0, r_len} + (LEN_W+1)'(LEN_MARGIN)) > (LEN_W+1)'(r_n);
    assign dec_done = (r_phase == PH_DEC) && !r_esc && (r_pos >= r_end);

    assign o_rd_en   = (r_state == SQ_RD) && !dec_done;
    assign o_rd_addr = r_pos[IDX_W-1:0];
    assign o_busy    = (r_state != SQ_IDLE);

    assign o_res_valid = emit || (r_state == SQ_FIN);

    always_comb begin
        o_res                 = '0;
        o_res.last            = 1'b1;
        if (r_state == SQ_FIN) begin
            o_res.status         = r_fin;
            o_res.payload_length = r_oi;
        end else begin
            o_res.status    = ST_BYTE;
            o_res.data_byte = dec_val;
            o_res.last      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_phase <= PH_HDR;
            r_esc   <= 1'b0;
        end else begin
            case (r_state)
                SQ_IDLE: begin
                    if (i_start) begin
                        r_state <= SQ_RD;
                        r_phase <= PH_HDR;
                        r_pos   <= CNT_W'(HDR_FIRST);
                        r_n     <= i_count;
                        r_len   <= '0;
                        r_crc   <= '0;
                        r_oi    <= '0;
                        r_esc   <= 1'b0;
                    end
                end
                SQ_RD: begin
                    if (dec_done) begin
                        r_fin   <= ST_OK;
                        r_state <= SQ_FIN;
                    end else begin
                        r_cur   <= r_pos;
                        r_pos   <= r_pos + CNT_W'(1);
                        r_state <= SQ_USE;
                    end
                end
                SQ_USE: begin
                    case (r_phase)
                        PH_HDR: begin
                            r_crc <= r_crc ^ i_rd_data;
                            if (r_cur == CNT_W'(HDR_FIRST)) begin
                                r_len <= r_len | LEN_W'(i_rd_data[7:4]);
                            end else if (r_cur == CNT_W'(HDR_FIRST + 1)) begin
                                r_len <= r_len | LEN_W'(i_rd_data);
                            end else if (r_cur == CNT_W'(HDR_FIRST + 2)) begin
                                r_len <= r_len | (LEN_W'(i_rd_data) << 4);
                            end else begin
                                r_len <= r_len | (LEN_W'(i_rd_data) << 8);
                            end
                            r_state <= (r_cur == CNT_W'(HDR_LAST)) ? SQ_LCK : SQ_RD;
                        end
                        PH_CHK: begin
                            if (r_cur < r_end) begin
                                r_crc   <= r_crc ^ i_rd_data;
                                r_state <= SQ_RD;
                            end else if (r_cur == r_end) begin
                                r_c0    <= i_rd_data;
                                r_state <= SQ_RD;
                            end else if (rx_sum != r_crc) begin
                                r_fin   <= ST_CRC_ERR;
                                r_state <= SQ_FIN;
                            end else begin
                                r_phase <= PH_DEC;
                                r_pos   <= CNT_W'(DATA_FIRST);
                                r_state <= SQ_RD;
                            end
                        end
                        default: begin
                            if (!emit || i_slot_free) begin
                                if (emit) begin
                                    r_oi <= r_oi + PLEN_W'(1);
                                end
                                r_esc   <= !r_esc && (i_rd_data == ESC_BYTE);
                                r_state <= SQ_RD;
                            end
                        end
                    endcase
                end
                SQ_LCK: begin
                    if (len_bad) begin
                        r_fin   <= ST_LEN_ERR;
                        r_state <= SQ_FIN;
                    end else begin
                        // data ends just before the checksum pair
                        r_end   <= r_len[CNT_W-1:0] + CNT_W'(DATA_FIRST);
                        r_phase <= PH_CHK;
                        r_state <= SQ_RD;
                    end
                end
                SQ_FIN: begin
                    if (i_slot_free) begin
                        r_state <= SQ_IDLE;
                    end
                end
                default: r_state <= SQ_IDLE;
            endcase
        end
    end

    a_read_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rd_en && r_phase != PH_HDR) |-> (r_pos < r_n))
        else $error("read past end of captured frame");

    a_count_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != SQ_IDLE && r_phase == PH_DEC) |-> (LEN_W'(r_oi) <= r_len))
        else $error("decoded more bytes than the length field");

    a_start_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == SQ_IDLE) |=> (r_state == SQ_RD && r_phase == PH_HDR))
        else $error("take did not start the header pass");
endmodule
`default_nettype wire

// ----- tb/frame_catch_and_decode_top_tb.sv -----
// Testbench for frame_catch_and_decode_top: framed byte streams and takes, checked result by result.
`timescale 1ns / 100ps
module frame_catch_and_decode_top_tb;
    import fcd_pkg::*;

    localparam int DEPTH        = BUF_DEPTH_DEF;
    localparam int MAX_RAW      = DEPTH - LEN_MARGIN;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_XFER = 40;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_line_item;

    // ways a generated frame can be spoiled on purpose
    typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_LEN, FLAW_TAIL_ESC} t_flaw;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    fcd_in_if  in_if ();
    fcd_out_if out_if ();

    frame_catch_and_decode_top #(
        .BUF_DEPTH (DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    t_line_item line_items [$];   // items waiting to be offered
    t_res       due_results [$];  // results still owed by the block

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int in_xfers      = 0;
    int hold_left     = 0;
    bit hold_armed    = 1'b1;
    int idle_cycles   = 0;
    int fail_count    = 0;

    // shadow copy of the capture logic
    logic [1:0]  cap_state;
    logic [7:0]  cap_mem [DEPTH];
    int unsigned cap_count;
    bit          pkg_held;

    initial begin
        cap_state = CS_IDLE;
        cap_count = 0;
        pkg_held  = 1'b0;
        foreach (cap_mem[k]) cap_mem[k] = 8'h00;
    end

    function automatic logic [7:0] mem_rd(input int unsigned idx);
        return (idx < DEPTH) ? cap_mem[idx] : 8'h00;
    endfunction

    function automatic void owe_result(input logic [STATUS_W-1:0] status,
                                       input logic [7:0] data, input logic [PLEN_W-1:0] plen,
                                       input logic waiting, input logic is_last);
        t_res r;
        r.status          = status;
        r.data_byte       = data;
        r.payload_length  = plen;
        r.package_waiting = waiting;
        r.last            = is_last;
        due_results.push_back(r);
    endfunction

    // Works out the results of one accepted transfer and advances the shadow state.
    function automatic void catch_and_decode(input logic cmd, input logic [7:0] b);
        int unsigned n, len, i, cnt;
        logic [7:0]  crc, rx_sum, c0, c1, v, nb;
        if (cmd == CMD_RX) begin
            if (pkg_held) begin
                cap_state = CS_LOCKED;
            end else if (b == START_BYTE) begin
                cap_mem[0] = START_BYTE;
                cap_count  = 1;
                cap_state  = CS_CATCHING;
            end else if (b == END_BYTE) begin
                if (cap_state != CS_CATCHING || cap_count >= DEPTH) begin
                    cap_state = CS_IDLE;
                    cap_count = 0;
                end else begin
                    cap_mem[cap_count] = END_BYTE;
                    cap_count++;
                    cap_state = CS_COMPLETE;
                    pkg_held  = 1'b1;
                end
            end else if (cap_state == CS_CATCHING) begin
                if (cap_count >= DEPTH) begin
                    // buffer full: frame abandoned
                    cap_state = CS_IDLE;
                    cap_count = 0;
                end else begin
                    cap_mem[cap_count] = b;
                    cap_count++;
                end
            end
            owe_result({2'b00, cap_state}, 8'h00, '0, pkg_held, 1'b1);
            return;
        end
        if (!pkg_held) begin
            owe_result(ST_NONE, 8'h00, '0, 1'b0, 1'b1);
            return;
        end
        // any take that finds a package unlocks and clears capture
        n         = cap_count;
        pkg_held  = 1'b0;
        cap_state = CS_IDLE;
        cap_count = 0;
        len = (32'(mem_rd(1)) >> 4) | 32'(mem_rd(2)) | (32'(mem_rd(3)) << 4)
            | (32'(mem_rd(4)) << 8);
        len &= 32'hFFFF;
        if (len + LEN_MARGIN > n) begin
            owe_result(ST_LEN_ERR, 8'h00, '0, 1'b0, 1'b1);
            return;
        end
        crc = 8'h00;
        for (i = HDR_FIRST; i <= len + HDR_LAST; i++) crc ^= mem_rd(i);
        c0     = mem_rd(len + DATA_FIRST);
        c1     = mem_rd(len + DATA_FIRST + 1);
        rx_sum = c1 | (c0 >> 4) | (c1 << 4);
        if (rx_sum != crc) begin
            owe_result(ST_CRC_ERR, 8'h00, '0, 1'b0, 1'b1);
            return;
        end
        cnt = 0;
        i   = 0;
        while (i < len) begin
            v = mem_rd(DATA_FIRST + i);
            if (v == ESC_BYTE) begin
                nb = mem_rd(DATA_FIRST + 1 + i);
                v  = (nb == ESC_BYTE) ? ESC_BYTE : (nb ^ FLIP_MASK);
                i += 2;
            end else begin
                i += 1;
            end
            owe_result(ST_BYTE, v, '0, 1'b0, 1'b0);
            cnt++;
        end
        owe_result(ST_OK, 8'h00, PLEN_W'(cnt), 1'b0, 1'b1);
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic void push_rx(input logic [7:0] b);
        line_items.push_back('{CMD_RX, b});
    endfunction

    function automatic void push_take();
        line_items.push_back('{CMD_TAKE, 8'($urandom)});
    endfunction

    // any byte other than the start and end bytes
    function automatic logic [7:0] plain_byte();
        logic [7:0] v;
        do v = 8'($urandom); while (v == START_BYTE || v == END_BYTE);
        return v;
    endfunction

    // payload value, biased toward the bytes that need escaping
    function automatic logic [7:0] pick_data();
        if ($urandom_range(3) != 0) return 8'($urandom);
        case ($urandom_range(7))
            0: return START_BYTE;
            1: return END_BYTE;
            2: return ESC_BYTE;
            3: return START_BYTE ^ FLIP_MASK;
            4: return END_BYTE ^ FLIP_MASK;
            5: return ESC_BYTE ^ FLIP_MASK;
            6: return 8'h00;
            default: return 8'hFF;
        endcase
    endfunction

    // mostly short payloads, now and then a long one, up to a full buffer
    function automatic int pick_payload_size();
        int r;
        r = $urandom_range(19);
        if (r < 14) return $urandom_range(0, 8);
        if (r < 18) return $urandom_range(9, 24);
        return $urandom_range(40, MAX_RAW);
    endfunction

    function automatic void add_noise(input int count);
        repeat (count) begin
            if ($urandom_range(3) == 0) push_take();
            else push_rx(8'($urandom));
        end
    endfunction

    // Encodes one frame: STX, length nibbles, escaped data, checksum pair, pad, ETX.
    function automatic void add_frame(input int n_dec, input t_flaw flaw);
        logic [7:0]  raw [$];
        logic [7:0]  v, b1, b2, b3, b4, crc, c0, c1;
        logic [15:0] plen;
        int          room, pads;
        room = (flaw == FLAW_TAIL_ESC) ? MAX_RAW - 1 : MAX_RAW;
        for (int k = 0; k < n_dec; k++) begin
            v = pick_data();
            if (raw.size() + 2 > room) break;
            if (v == ESC_BYTE) begin
                raw.push_back(ESC_BYTE);
                raw.push_back(ESC_BYTE);
            end else if (v == START_BYTE || v == END_BYTE
                         || ((v ^ FLIP_MASK) != START_BYTE && (v ^ FLIP_MASK) != END_BYTE
                             && (v ^ FLIP_MASK) != ESC_BYTE && $urandom_range(9) == 0)) begin
                raw.push_back(ESC_BYTE);
                raw.push_back(v ^ FLIP_MASK);
            end else begin
                raw.push_back(v);
            end
        end
        // lone escape at the end of the data: it pairs with the first checksum byte
        if (flaw == FLAW_TAIL_ESC) raw.push_back(ESC_BYTE);

        plen = 16'(raw.size());
        b1   = {plen[3:0], 4'($urandom)};
        if (b1 == START_BYTE || b1 == END_BYTE) b1[3:0] = 4'h0;
        b2   = plen[7:0] & 8'($urandom);   // OR-ed in, so any subset of the bits works
        b3   = {4'h0, plen[7:4]};
        b4   = 8'h00;
        if (flaw == FLAW_LEN) begin
            if ($urandom_range(1) == 0) b4 = 8'($urandom_range(1, 8'hF9));
            else b2 |= 8'h40;
        end
        crc = b1 ^ b2 ^ b3 ^ b4;
        foreach (raw[k]) crc ^= raw[k];
        c0 = {crc[3:0], 4'h0};
        c1 = {crc[7:4], 4'h0};
        if (flaw == FLAW_SUM) c1 ^= 8'h10 << $urandom_range(3);

        pads = 0;
        if ($urandom_range(4) == 0) pads = $urandom_range(1, 3);
        if (raw.size() + LEN_MARGIN + pads > DEPTH) pads = DEPTH - LEN_MARGIN - raw.size();

        push_rx(START_BYTE);
        push_rx(b1);
        push_rx(b2);
        push_rx(b3);
        push_rx(b4);
        foreach (raw[k]) push_rx(raw[k]);
        push_rx(c0);
        push_rx(c1);
        repeat (pads) push_rx(plain_byte());
        push_rx(END_BYTE);
    endfunction

    // STX plus body bytes, then ETX and a take; body sizes near the buffer limit
    function automatic void add_overflow(input int body);
        push_rx(START_BYTE);
        repeat (body) push_rx(plain_byte());
        push_rx(END_BYTE);
        push_take();
    endfunction

    function automatic void gen_random(input int target);
        int base, r;
        base = line_items.size();
        while (line_items.size() - base < target) begin
            r = $urandom_range(99);
            if (r < 50) begin
                if ($urandom_range(4) == 0) add_noise($urandom_range(1, 3));
                add_frame(pick_payload_size(), FLAW_NONE);
                // bytes that land while locked (a take among them unlocks early)
                if ($urandom_range(3) == 0) add_noise($urandom_range(1, 2));
                push_take();
            end else if (r < 60) begin
                add_frame(pick_payload_size(), FLAW_SUM);
                push_take();
            end else if (r < 67) begin
                add_frame(pick_payload_size(), FLAW_LEN);
                push_take();
            end else if (r < 73) begin
                add_frame(pick_payload_size(), FLAW_TAIL_ESC);
                push_take();
            end else if (r < 80) begin
                // aborted start, then a clean frame restarts capture
                push_rx(START_BYTE);
                repeat ($urandom_range(1, 6)) push_rx(plain_byte());
                add_frame(pick_payload_size(), FLAW_NONE);
                push_take();
            end else if (r < 82) begin
                add_overflow(DEPTH - 2 + $urandom_range(2));
            end else begin
                add_noise($urandom_range(1, 4));
            end
        end
    endfunction

    // ---------------- input driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                catch_and_decode(in_if.cmd, in_if.rx_byte);
                in_xfers <= in_xfers + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (line_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_if.valid   <= 1'b1;
                    in_if.cmd     <= line_items[0].cmd;
                    in_if.rx_byte <= line_items[0].rx_byte;
                    void'(line_items.pop_front());
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off early in the run, so the block backs up
    // and stalls its input while the sender keeps offering.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_armed && in_xfers == HOLD_AT_XFER) begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------- result monitor ----------------
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with none expected: status %0d data %0h",
                           out_if.status, out_if.data_byte);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (out_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_if.status);
                        fail_count++;
                    end
                    if (out_if.data_byte !== want.data_byte) begin
                        $error("data_byte: expected %0h, got %0h",
                               want.data_byte, out_if.data_byte);
                        fail_count++;
                    end
                    if (out_if.payload_length !== want.payload_length) begin
                        $error("payload_length: expected %0d, got %0d",
                               want.payload_length, out_if.payload_length);
                        fail_count++;
                    end
                    if (out_if.package_waiting !== want.package_waiting) begin
                        $error("package_waiting: expected %0b, got %0b",
                               want.package_waiting, out_if.package_waiting);
                        fail_count++;
                    end
                    if (out_if.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, out_if.last);
                        fail_count++;
                    end
                end
            end
            out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------- watchdog: cycles without any transfer ----------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ---------------- sequence ----------------
    initial begin
        in_if.valid   = 1'b0;
        in_if.cmd     = CMD_RX;
        in_if.rx_byte = 8'h00;
        out_if.ready  = 1'b0;

        // Directed opening. The first complete frame is a clean one with a
        // zero length, so every header entry is written before any later
        // short frame reads it.
        push_take();                       // take with nothing waiting
        push_rx(END_BYTE);                 // ETX while idle
        push_rx(START_BYTE);
        repeat (4) push_rx(8'h00);
        push_rx(8'h00);
        push_rx(8'h00);
        push_rx(END_BYTE);
        push_rx(8'hFF);                    // dropped while locked
        push_take();                       // empty payload, package ok
        push_rx(START_BYTE);
        push_rx(END_BYTE);
        push_take();                       // too short for its length field
        push_rx(START_BYTE);
        repeat (4) push_rx(8'h00);
        push_rx(8'h00);
        push_rx(8'h10);                    // checksum pair says 0x10, data sums to 0
        push_rx(END_BYTE);
        push_take();
        gen_random(90);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles half the time
        while (line_items.size() != 0) @(posedge i_clk);
        send_idle_pct <= 50;
        add_overflow(DEPTH - 1);
        gen_random(50);

        // receiver stalls half the time
        while (line_items.size() != 0) @(posedge i_clk);
        send_idle_pct <= 0;
        stall_pct     <= 50;
        gen_random(115);

        // both sides idle about a third of the time
        while (line_items.size() != 0) @(posedge i_clk);
        send_idle_pct <= 32;
        stall_pct     <= 32;
        gen_random(115);

        while (line_items.size() != 0 || in_if.valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
